>>> sv/multiversion_hash_index_top_assert.svh
// assertion macros used by the checker file
`ifndef MULTIVERSION_HASH_INDEX_TOP_ASSERT_SVH
`define MULTIVERSION_HASH_INDEX_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MHI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mhi check failed");

// next-cycle implication, sampled on clk, off during reset
`define MHI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mhi check failed");

`endif

>>> sv/mhi_pkg.sv
package mhi_pkg;

	localparam int NUM_BUCKETS  = 256;
	localparam int BUCKET_SLOTS = 16;
	localparam int HEADER_BYTES = 14;
	localparam logic [33:0] DATA_BYTES = 34'd1048576;

	localparam int TOTAL_SLOTS = NUM_BUCKETS * BUCKET_SLOTS;
	localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int SLOT_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int CNT_W  = $clog2(BUCKET_SLOTS + 1);
	localparam int WORD_W = 64 + 64 + 32;

	// operation codes
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_PRD,
		S_PEV,
		S_PWR,
		S_GRD,
		S_GEV
	} state_t;

	// flags from the shared slot compare unit
	typedef struct packed {
		logic hash_eq;
		logic goes_before;
		logic get_better;
	} cmp_res_t;

	// slot word: hash, packed version, offset
	function automatic logic [WORD_W-1:0] slot_pack(input logic [63:0] h,
			input logic [63:0] pv, input logic [31:0] off);
		return {h, pv, off};
	endfunction

endpackage

>>> sv/mhi_ram.sv
module mhi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/mhi_cmp.sv
module mhi_cmp import mhi_pkg::*; (
	input  logic [63:0] slot_hash,
	input  logic [63:0] slot_pv,
	input  logic [63:0] key_hash,
	input  logic [63:0] new_pv,
	input  logic [63:0] bound,
	input  logic [63:0] best_pv,
	input  logic        best_found,
	output cmp_res_t    res
);

	logic eq;
	assign eq = (slot_hash == key_hash);

	// sort order and get selection for one slot
	always_comb begin
		res.hash_eq     = eq;
		res.goes_before = (slot_hash < key_hash) || (eq && (slot_pv > new_pv));
		res.get_better  = eq && (slot_pv <= bound) && (!best_found || (slot_pv > best_pv));
	end

endmodule

>>> sv/multiversion_hash_index_top.sv
// flow: clear and no-op respond from idle; put and get read the bucket fill first, and a put
// without room is dropped; a put shifts up to 15 slots, stopping at one that sorts before it, then writes;
// a get scans the current bucket fill; each step of a walk is one slot memory read and a compare
// throughput: one word at a time, next word taken after the result is consumed
// reset: asynchronous; bucket fills, data pointer and counts clear, slot memory is
// left as is and only used below each bucket's fill
module multiversion_hash_index_top import mhi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  opcode,
	input  logic [63:0] key_hash,
	input  logic [62:0] version,
	input  logic        tombstone,
	input  logic [15:0] key_len,
	input  logic [31:0] val_len,
	input  logic [63:0] ver_bound,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        found,
	output logic [31:0] record_offset,
	output logic [62:0] found_version,
	output logic        found_tombstone,
	output logic        no_room,
	output logic [12:0] entry_count,
	output logic [12:0] distinct_keys
);

	state_t state_q, state_d;

	logic              [1:0] op_q;
	logic             [63:0] hash_q;
	logic             [63:0] pv_q;
	logic             [33:0] size_q;
	logic             [63:0] bound_q;
	logic        [BKT_W-1:0] bkt_q;
	logic       [SLOT_W-1:0] base_q;
	logic        [CNT_W-1:0] cnt_q;
	logic        [CNT_W-1:0] idx_q;
	logic                    exists_q;
	logic             [31:0] off_q;
	logic             [63:0] best_pv_q;
	logic             [31:0] best_off_q;
	logic                    best_found_q;
	logic             [31:0] data_end_q;
	logic             [12:0] entries_q;
	logic             [12:0] keys_q;
	logic  [NUM_BUCKETS-1:0] fill_vld_q;

	logic                    accept;
	logic        [BKT_W-1:0] fill_raddr;
	logic        [CNT_W-1:0] fill_rdata;
	logic        [CNT_W-1:0] fill_cnt;
	logic                    fill_we;
	logic       [SLOT_W-1:0] slot_raddr;
	logic       [SLOT_W-1:0] slot_waddr;
	logic       [WORD_W-1:0] slot_wdata;
	logic       [WORD_W-1:0] slot_rdata;
	logic                    slot_we;
	logic             [63:0] rd_hash;
	logic             [63:0] rd_pv;
	logic             [31:0] rd_off;
	logic             [33:0] data_sum;
	logic                    put_full;
	cmp_res_t                cmp;

	assign req_ready = (state_q == S_IDLE) && !rsp_valid;
	assign accept    = req_valid && req_ready;

	assign rd_hash = slot_rdata[WORD_W-1 -: 64];
	assign rd_pv   = slot_rdata[WORD_W-65 -: 64];
	assign rd_off  = slot_rdata[31:0];

	// bucket fill memory, unwritten fills read as zero
	assign fill_raddr = (state_q == S_IDLE) ? key_hash[BKT_W-1:0] : bkt_q;
	assign fill_cnt   = fill_vld_q[bkt_q] ? fill_rdata : '0;
	assign fill_we    = (state_q == S_PWR);

	mhi_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS)) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (bkt_q),
		.wdata (CNT_W'(cnt_q + 1'b1)),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	mhi_ram #(.WIDTH(WORD_W), .DEPTH(TOTAL_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	mhi_cmp u_cmp (
		.slot_hash  (rd_hash),
		.slot_pv    (rd_pv),
		.key_hash   (hash_q),
		.new_pv     (pv_q),
		.bound      (bound_q),
		.best_pv    (best_pv_q),
		.best_found (best_found_q),
		.res        (cmp)
	);

	// room check for a put
	assign data_sum = {2'b00, data_end_q} + size_q;
	assign put_full = (fill_cnt >= CNT_W'(BUCKET_SLOTS)) || (data_sum > DATA_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and memory controls
	always_comb begin
		state_d    = state_q;
		slot_raddr = base_q + SLOT_W'(idx_q);
		slot_waddr = base_q + SLOT_W'(idx_q);
		slot_wdata = slot_rdata;
		slot_we    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && (opcode == OP_PUT || opcode == OP_GET)) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				if (op_q == OP_PUT) begin
					state_d = put_full ? S_IDLE : S_PRD;
				end else begin
					state_d = S_GRD;
				end
			end
			S_PRD: begin
				slot_raddr = base_q + SLOT_W'(idx_q) - 1'b1;
				state_d = (idx_q == '0) ? S_PWR : S_PEV;
			end
			S_PEV: begin
				if (cmp.goes_before) begin
					state_d = S_PWR;
				end else begin
					slot_we = 1'b1;
					state_d = S_PRD;
				end
			end
			S_PWR: begin
				slot_we    = 1'b1;
				slot_wdata = slot_pack(hash_q, pv_q, off_q);
				state_d    = S_IDLE;
			end
			S_GRD: begin
				state_d = (idx_q == cnt_q) ? S_IDLE : S_GEV;
			end
			S_GEV: begin
				state_d = S_GRD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state: counts, fills, data pointer, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q <= '0;
			data_end_q <= '0;
			entries_q  <= '0;
			keys_q     <= '0;
			rsp_valid  <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && opcode != OP_PUT && opcode != OP_GET) begin
						rsp_valid <= 1'b1;
						if (opcode == OP_CLEAR) begin
							fill_vld_q <= '0;
							data_end_q <= '0;
							entries_q  <= '0;
							keys_q     <= '0;
						end
					end
				end
				S_FILL: begin
					if (op_q == OP_PUT) begin
						if (put_full) begin
							rsp_valid <= 1'b1;
						end else begin
							data_end_q <= data_sum[31:0];
						end
					end
				end
				S_PWR: begin
					fill_vld_q[bkt_q] <= 1'b1;
					entries_q <= entries_q + 1'b1;
					if (!exists_q) begin
						keys_q <= keys_q + 1'b1;
					end
					rsp_valid <= 1'b1;
				end
				S_GRD: begin
					if (idx_q == cnt_q) begin
						rsp_valid <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers and result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= opcode;
					hash_q  <= key_hash;
					pv_q    <= {version, tombstone};
					size_q  <= 34'(HEADER_BYTES) + 34'(key_len) + 34'(val_len);
					bound_q <= ver_bound;
					bkt_q   <= key_hash[BKT_W-1:0];
					base_q  <= SLOT_W'(SLOT_W'(key_hash[BKT_W-1:0]) * SLOT_W'(BUCKET_SLOTS));
					found           <= 1'b0;
					record_offset   <= '0;
					found_version   <= '0;
					found_tombstone <= 1'b0;
					no_room         <= 1'b0;
					entry_count     <= (opcode == OP_CLEAR) ? 13'd0 : entries_q;
					distinct_keys   <= (opcode == OP_CLEAR) ? 13'd0 : keys_q;
				end
			end
			S_FILL: begin
				cnt_q        <= fill_cnt;
				exists_q     <= 1'b0;
				best_found_q <= 1'b0;
				best_pv_q    <= '0;
				best_off_q   <= '0;
				off_q        <= data_end_q;
				idx_q        <= (op_q == OP_PUT) ? fill_cnt : '0;
				if (op_q == OP_PUT && put_full) begin
					no_room <= 1'b1;
				end
			end
			S_PRD: begin
				if (idx_q == '0) begin
					idx_q <= '0;
				end
			end
			S_PEV: begin
				exists_q <= exists_q | cmp.hash_eq;
				if (!cmp.goes_before) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			S_PWR: begin
				record_offset <= off_q;
				entry_count   <= entries_q + 1'b1;
				distinct_keys <= exists_q ? keys_q : keys_q + 1'b1;
			end
			S_GRD: begin
				if (idx_q == cnt_q) begin
					found           <= best_found_q;
					record_offset   <= best_off_q;
					found_version   <= best_pv_q[63:1];
					found_tombstone <= best_pv_q[0];
				end
			end
			S_GEV: begin
				if (cmp.get_better) begin
					best_found_q <= 1'b1;
					best_pv_q    <= rd_pv;
					best_off_q   <= rd_off;
				end
				idx_q <= idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/mhi_checker.sv
`include "multiversion_hash_index_top_assert.svh"

module mhi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        found,
	input logic [31:0] record_offset,
	input logic        no_room,
	input logic [12:0] entry_count
);

	// a stalled response word holds
	`MHI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(record_offset))

	// no new word while a response waits
	`MHI_ASSERT_IMP(a_busy_rsp, rsp_valid, !req_ready)

	// a taken word keeps the block busy in the next cycle
	`MHI_ASSERT_NXT(a_busy_next, req_valid && req_ready, !req_ready)

	// a dropped put never reports a hit
	`MHI_ASSERT_IMP(a_drop_nohit, rsp_valid && no_room, !found && record_offset == 32'd0)

	// entry count stays within the slot total
	`MHI_ASSERT_IMP(a_count_max, rsp_valid, entry_count <= 13'd4096)

endmodule

bind multiversion_hash_index_top mhi_checker u_mhi_checker (.*);

>>> test/multiversion_hash_index_top_test.sv
`timescale 1ns / 100ps

module multiversion_hash_index_top_test;
	import mhi_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 500;

	typedef struct {
		bit          found;
		logic [31:0] offset;
		logic [62:0] version;
		bit          tomb;
		bit          no_room;
		logic [12:0] entries;
		logic [12:0] keys;
	} index_rsp_t;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] hash;
		logic [62:0] version;
		logic        tomb;
		logic [15:0] key_len;
		logic [31:0] val_len;
		logic [63:0] bound;
		bit          typed;
		index_rsp_t  typed_rsp;
	} index_word_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        req_valid = 0;
	logic        req_ready;
	logic [1:0]  opcode = '0;
	logic [63:0] key_hash = '0;
	logic [62:0] version = '0;
	logic        tombstone = 0;
	logic [15:0] key_len = '0;
	logic [31:0] val_len = '0;
	logic [63:0] ver_bound = '0;
	logic        rsp_valid;
	logic        rsp_ready = 0;
	logic        found;
	logic [31:0] record_offset;
	logic [62:0] found_version;
	logic        found_tombstone;
	logic        no_room;
	logic [12:0] entry_count;
	logic [12:0] distinct_keys;

	multiversion_hash_index_top dut (.*);

	always #6 clk = ~clk;

	// shadow copy of the index
	logic [63:0] sh_hash [NUM_BUCKETS][BUCKET_SLOTS];
	logic [63:0] sh_pv [NUM_BUCKETS][BUCKET_SLOTS];
	logic [31:0] sh_off [NUM_BUCKETS][BUCKET_SLOTS];
	int          sh_fill [NUM_BUCKETS];
	logic [63:0] sh_data_end = '0;
	logic [12:0] sh_entries = '0;
	logic [12:0] sh_keys = '0;

	index_rsp_t  rsp_queue [$];
	index_word_t dir_words [$];
	int          errors = 0;
	int          words_sent = 0;
	int          stall_cycles = 0;
	bit          held = 0;
	logic [63:0] hash_pool [24];

	// predict one result and update the shadow index
	function automatic index_rsp_t index_step(index_word_t w);
		index_rsp_t  r;
		logic [63:0] pv;
		logic [63:0] size;
		logic [63:0] best;
		int          b, cnt, pos;
		bit          seen;
		r = '{0, '0, '0, 0, 0, '0, '0};
		b = int'(w.hash % NUM_BUCKETS);
		cnt = sh_fill[b];
		case (w.op)
			OP_PUT: begin
				pv = {w.version, w.tomb};
				size = 64'(HEADER_BYTES) + 64'(w.key_len) + 64'(w.val_len);
				if (cnt >= BUCKET_SLOTS || sh_data_end + size > 64'(DATA_BYTES)) begin
					r.no_room = 1;
				end else begin
					r.offset = sh_data_end[31:0];
					sh_data_end += size;
					seen = 0;
					for (int i = 0; i < cnt; i++)
						if (sh_hash[b][i] == w.hash) seen = 1;
					pos = 0;
					while (pos < cnt && (sh_hash[b][pos] < w.hash ||
							(sh_hash[b][pos] == w.hash && sh_pv[b][pos] > pv)))
						pos++;
					for (int i = cnt; i > pos; i--) begin
						sh_hash[b][i] = sh_hash[b][i-1];
						sh_pv[b][i] = sh_pv[b][i-1];
						sh_off[b][i] = sh_off[b][i-1];
					end
					sh_hash[b][pos] = w.hash;
					sh_pv[b][pos] = pv;
					sh_off[b][pos] = r.offset;
					sh_fill[b] = cnt + 1;
					sh_entries++;
					if (!seen) sh_keys++;
				end
			end
			OP_GET: begin
				best = '0;
				for (int i = 0; i < cnt; i++) begin
					if (sh_hash[b][i] == w.hash && sh_pv[b][i] <= w.bound &&
							(!r.found || sh_pv[b][i] > best)) begin
						best = sh_pv[b][i];
						r.offset = sh_off[b][i];
						r.found = 1;
					end
				end
				if (r.found) begin
					r.version = best[63:1];
					r.tomb = best[0];
				end
			end
			OP_CLEAR: begin
				foreach (sh_fill[i]) sh_fill[i] = 0;
				sh_data_end = '0;
				sh_entries = '0;
				sh_keys = '0;
			end
			default: ;
		endcase
		r.entries = sh_entries;
		r.keys = sh_keys;
		return r;
	endfunction

	function automatic index_word_t mk(logic [1:0] op, logic [63:0] h, logic [62:0] v,
			logic t, logic [15:0] kl, logic [31:0] vl, logic [63:0] ub);
		index_word_t w;
		w = '{op, h, v, t, kl, vl, ub, 0, '{0, '0, '0, 0, 0, '0, '0}};
		return w;
	endfunction

	function automatic index_word_t typed_as(index_word_t w, index_rsp_t r);
		w.typed = 1;
		w.typed_rsp = r;
		return w;
	endfunction

	// append one row to the directed table
	function automatic void add_row(index_word_t w);
		dir_words.insert(dir_words.size(), w);
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic index_word_t random_word();
		index_word_t w;
		int r;
		w = mk(OP_PUT, '0, '0, 0, '0, '0, '0);
		r = $urandom_range(0, 99);
		w.op = (r < 52) ? OP_PUT : (r < 92) ? OP_GET : (r < 96) ? OP_CLEAR : OP_NOP;
		if ($urandom_range(0, 9) == 0) w.hash = {$urandom, $urandom};
		else w.hash = hash_pool[$urandom_range(0, 23)];
		if ($urandom_range(0, 19) == 0) w.version = 63'({$urandom, $urandom});
		else w.version = 63'($urandom_range(0, 15));
		w.tomb = 1'($urandom_range(0, 1));
		w.key_len = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		r = $urandom_range(0, 99);
		if (r < 3) w.val_len = $urandom;
		else if (r < 7) w.val_len = $urandom_range(100000, 300000);
		else w.val_len = $urandom_range(0, 200);
		r = $urandom_range(0, 99);
		if (r < 40) w.bound = '1;
		else if (r < 45) w.bound = {$urandom, $urandom};
		else w.bound = 64'($urandom_range(0, 40));
		return w;
	endfunction

	// offer one word and predict its result once it is taken
	task automatic send_word(index_word_t w);
		int g;
		index_rsp_t p;
		g = pick_gap();
		if (g > 0) begin
			req_valid <= 0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1;
		opcode <= w.op;
		key_hash <= w.hash;
		version <= w.version;
		tombstone <= w.tomb;
		key_len <= w.key_len;
		val_len <= w.val_len;
		ver_bound <= w.bound;
		do @(posedge clk); while (!req_ready);
		p = index_step(w);
		rsp_queue.insert(rsp_queue.size(), w.typed ? w.typed_rsp : p);
		words_sent++;
	endtask

	function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
		if (exp !== act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			errors++;
		end
	endfunction

	// compare each returned word with the oldest prediction
	always @(posedge clk) begin
		index_rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_queue.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = rsp_queue.pop_front();
				check_field("found", e.found, found);
				check_field("record_offset", e.offset, record_offset);
				check_field("found_version", e.version, found_version);
				check_field("found_tombstone", e.tomb, found_tombstone);
				check_field("no_room", e.no_room, no_room);
				check_field("entry_count", e.entries, entry_count);
				check_field("distinct_keys", e.keys, distinct_keys);
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("multiversion_hash_index_top: mismatch");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off to back up the input
	initial begin
		int g;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && words_sent >= 300) begin
				rsp_ready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1;
			end else begin
				g = pick_gap();
				if (g > 0) begin
					rsp_ready <= 0;
					repeat (g) @(posedge clk);
				end
				rsp_ready <= 1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		index_rsp_t zero;
		zero = '{0, '0, '0, 0, 0, '0, '0};
		foreach (sh_fill[i]) sh_fill[i] = 0;
		// few buckets, several hashes each, so buckets fill up
		foreach (hash_pool[i])
			hash_pool[i] = {$urandom, 24'($urandom), 8'($urandom_range(0, 3))};

		// empty index, extremes, equal versions, no-op, near-full buffer, clear
		add_row(typed_as(mk(OP_GET, '0, '0, 0, '0, '0, '1), zero));
		add_row(typed_as(mk(OP_PUT, '0, '0, 0, '0, '0, '0),
			'{0, '0, '0, 0, 0, 13'd1, 13'd1}));
		add_row(typed_as(mk(OP_PUT, '1, '1, 1, '1, '1, '0),
			'{0, '0, '0, 0, 1, 13'd1, 13'd1}));
		add_row(mk(OP_PUT, '1, '1, 1, '1, '0, '0));
		add_row(mk(OP_GET, '1, '0, 0, '0, '0, '1));
		add_row(mk(OP_GET, '1, '0, 0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE));
		add_row(mk(OP_PUT, 64'h100, 63'd3, 0, 16'd5, 32'd10, '0));
		add_row(mk(OP_PUT, 64'h100, 63'd3, 1, 16'd5, 32'd10, '0));
		add_row(mk(OP_PUT, 64'h100, 63'd3, 0, 16'd7, 32'd1, '0));
		add_row(mk(OP_GET, 64'h100, '0, 0, '0, '0, 64'd6));
		add_row(mk(OP_GET, 64'h100, '0, 0, '0, '0, 64'd7));
		add_row(mk(OP_GET, 64'h100, '0, 0, '0, '0, 64'd5));
		add_row(mk(OP_GET, 64'h200, '0, 0, '0, '0, '1));
		add_row(mk(OP_NOP, '1, '1, 1, '1, '1, '1));
		add_row(mk(OP_PUT, 64'h55, '0, 0, '0, 32'h000F_FFF0, '0));
		add_row(mk(OP_PUT, 64'h56, 63'd1, 0, '0, '0, '0));
		add_row(typed_as(mk(OP_CLEAR, '1, '1, 1, '1, '1, '1), zero));
		add_row(typed_as(mk(OP_PUT, 64'hAAAA_5555_AAAA_5555, 63'h2AAA_5555_AAAA_5555,
			0, 16'd1, 32'd1, '0), '{0, '0, '0, 0, 0, 13'd1, 13'd1}));
		add_row(mk(OP_GET, 64'hAAAA_5555_AAAA_5555, '0, 0, '0, '0, '1));

		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_words[i]) send_word(dir_words[i]);
		repeat (700) send_word(random_word());
		req_valid <= 0;

		while (rsp_queue.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("multiversion_hash_index_top: match");
		end else begin
			$display("multiversion_hash_index_top: mismatch");
		end
		$finish;
	end

endmodule

>>> multiversion_hash_index_top.f
+incdir+sv
sv/mhi_pkg.sv
sv/mhi_ram.sv
sv/mhi_cmp.sv
sv/multiversion_hash_index_top.sv
sv/mhi_checker.sv
test/multiversion_hash_index_top_test.sv
